@@ design/clt_pkg.sv @@
// Shared types, constants and helper functions for the command line tokeniser.
// Used by the controller, the datapath and the top level; depends on nothing else.
package clt_pkg;

    localparam int HOLD_DEPTH_DEF = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [7:0]  QUOTE_CHAR  = 8'h22;
    localparam logic [7:0]  EQUALS_CHAR = 8'h3D;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam logic [15:0] COUNT_LIMIT = 16'hFFFE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IGNORE_QUOTES = 2'd0,
        CFG_UPPER_KEYS    = 2'd1,
        CFG_KV_MODE       = 2'd2,
        CFG_SEPARATOR     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       end_of_buffer;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] param_count;
        logic        parse_done;
        logic        run_last;
    } t_out_req;

    // What follows the release of the held bytes.
    typedef enum logic [1:0] {
        POST_STATUS = 2'd0,
        POST_EOB    = 2'd1,
        POST_NEW    = 2'd2,
        POST_APPEND = 2'd3
    } t_post;

    typedef struct packed {
        logic accept;
        logic eval;
        logic rd;
        logic emit;
        logic tail;
        logic tail_status;
        logic last;
        logic store;
        logic new_token;
    } t_cmd;

    typedef struct packed {
        logic finished;
        logic stop;
        logic eob;
        logic new_tok;
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

endpackage

@@ design/command_line_tokenizer.sv @@
// Command line tokeniser top level: joins the controller and the datapath.
// Depends on clt_pkg, clt_ctrl and clt_dp.
//
// The block takes one command byte per request and rewrites it, turning unquoted
// separators, quotes (unless ignored) and (in key-value mode) unquoted equals signs
// into zero bytes. A byte that is only held is accepted, classified and then written
// into the hold. A byte that arrives after the end of a command is accepted and
// classified only. Releasing a held byte takes a hold memory read and then a write
// of the output register. The closing result, or the write of the byte that starts
// the next token, follows the release. The held token is limited to HOLD_DEPTH bytes,
// and a byte that meets a full hold first releases the oldest held byte and is then
// written into the hold. Output stalls hold back the release and the closing result.
// Input is stalled while a byte is in progress.
module command_line_tokenizer #(
    parameter int HOLD_DEPTH = clt_pkg::HOLD_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  clt_pkg::t_in_req               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output clt_pkg::t_out_req              o_out_data,
    input  logic                           i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    clt_pkg::t_cmd  cmd;
    clt_pkg::t_stat stat;

    clt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    clt_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

@@ design/clt_ctrl.sv @@
// Controller state machine of the command line tokeniser.
// Depends on clt_pkg; drives the datapath through t_cmd and reads t_stat.
module clt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  clt_pkg::t_stat i_stat,
    output clt_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_RD    = 6'b000100,
        S_EMIT  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_STORE = 6'b100000
    } t_state;

    t_state         r_state, n_state;
    clt_pkg::t_post r_post, n_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= clt_pkg::POST_STATUS;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.finished) begin
                    n_state = S_IDLE;
                end else if (i_stat.stop) begin
                    n_post  = clt_pkg::POST_STATUS;
                    n_state = i_stat.cnt_zero ? S_TAIL : S_RD;
                end else if (i_stat.eob) begin
                    n_post  = clt_pkg::POST_EOB;
                    n_state = i_stat.cnt_zero ? S_TAIL : S_RD;
                end else if (i_stat.new_tok) begin
                    n_post  = clt_pkg::POST_NEW;
                    n_state = i_stat.cnt_zero ? S_STORE : S_RD;
                end else begin
                    n_post  = clt_pkg::POST_APPEND;
                    n_state = i_stat.full ? S_RD : S_STORE;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_post == clt_pkg::POST_APPEND) ||
                                 (i_stat.cnt_one && r_post == clt_pkg::POST_NEW);
                    if (r_post == clt_pkg::POST_APPEND) begin
                        n_state = S_STORE;
                    end else if (i_stat.cnt_one) begin
                        n_state = (r_post == clt_pkg::POST_NEW) ? S_STORE : S_TAIL;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_TAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.tail        = 1'b1;
                    o_cmd.tail_status = (r_post == clt_pkg::POST_STATUS);
                    n_state           = S_IDLE;
                end
            end
            S_STORE: begin
                o_cmd.store     = 1'b1;
                o_cmd.new_token = (r_post == clt_pkg::POST_NEW);
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/clt_dp.sv @@
// Datapath of the command line tokeniser: configuration, parse state, hold memory
// and output register. Depends on clt_pkg; sequenced by clt_ctrl.
module clt_dp #(
    parameter int HOLD_DEPTH = clt_pkg::HOLD_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  clt_pkg::t_cmd                i_cmd,
    output clt_pkg::t_stat               o_stat,
    input  clt_pkg::t_in_req             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output clt_pkg::t_out_req            o_out_data,
    input  logic                         i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int SW = CW + 1;

    logic        r_ignore_quotes, r_upper_keys, r_kv_mode;
    logic [7:0]  r_sep_char;

    logic [7:0]  r_byte, r_n;
    logic        r_eob;
    logic        r_in_string, r_prev_zero, r_finished, r_upper_flag;
    logic [15:0] r_bcount;
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_cnt;

    logic [7:0]  mem [HOLD_DEPTH];
    logic [7:0]  r_rd_data;

    logic        r_out_valid;
    clt_pkg::t_out_req r_out;

    logic        is_quote, is_sep, is_eq, n_zero;
    logic [7:0]  n_byte;
    logic [SW-1:0] tail_sum;
    logic [PW-1:0] tail_ptr, head_inc;
    logic        out_free;

    always_comb begin
        is_quote = !r_ignore_quotes && (r_byte == clt_pkg::QUOTE_CHAR);
        is_sep   = !is_quote && !r_in_string && (r_byte == r_sep_char);
        is_eq    = !is_quote && !is_sep && !r_in_string && r_kv_mode &&
                   (r_byte == clt_pkg::EQUALS_CHAR);
        n_byte   = (is_quote || is_sep || is_eq) ? clt_pkg::ZERO_BYTE : r_byte;
        n_zero   = (n_byte == clt_pkg::ZERO_BYTE);
        tail_sum = SW'(r_head) + SW'(r_cnt);
        if (tail_sum >= SW'(HOLD_DEPTH)) begin
            tail_sum = tail_sum - SW'(HOLD_DEPTH);
        end
        tail_ptr = tail_sum[PW-1:0];
        head_inc = (r_head == PW'(HOLD_DEPTH - 1)) ? '0 : r_head + PW'(1);
        out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        o_stat.finished = r_finished;
        o_stat.stop     = (r_byte == clt_pkg::ZERO_BYTE) || (r_bcount >= clt_pkg::COUNT_LIMIT);
        o_stat.eob      = r_eob;
        o_stat.new_tok  = !n_zero && r_prev_zero;
        o_stat.full     = (r_cnt == CW'(HOLD_DEPTH));
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.cnt_one  = (r_cnt == CW'(1));
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_quotes <= 1'b0;
            r_upper_keys    <= 1'b1;
            r_kv_mode       <= 1'b0;
            r_sep_char      <= 8'd32;
        end else if (i_cfg_we) begin
            unique case (clt_pkg::t_cfg_idx'(i_cfg_index))
                clt_pkg::CFG_IGNORE_QUOTES: r_ignore_quotes <= i_cfg_data[0];
                clt_pkg::CFG_UPPER_KEYS:    r_upper_keys    <= i_cfg_data[0];
                clt_pkg::CFG_KV_MODE:       r_kv_mode       <= i_cfg_data[0];
                clt_pkg::CFG_SEPARATOR:     r_sep_char      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_in_data.in_byte;
            r_eob  <= i_in_data.end_of_buffer;
        end
        if (i_cmd.eval) begin
            r_n <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string  <= 1'b0;
            r_prev_zero  <= 1'b0;
            r_finished   <= 1'b1;
            r_upper_flag <= 1'b0;
            r_bcount     <= '0;
            r_head       <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cmd.accept && i_in_data.first_byte) begin
                r_in_string  <= 1'b0;
                r_prev_zero  <= 1'b1;
                r_finished   <= 1'b0;
                r_upper_flag <= 1'b0;
                r_bcount     <= '0;
                r_cnt        <= '0;
            end
            if (i_cmd.eval && !r_finished) begin
                if (o_stat.stop) begin
                    r_finished <= 1'b1;
                end else begin
                    if (is_quote) begin
                        r_in_string <= !r_in_string;
                    end
                    if (n_zero && !r_prev_zero) begin
                        r_bcount <= r_bcount + 16'd1;
                    end
                    r_prev_zero <= n_zero;
                    if (is_eq && r_upper_keys) begin
                        r_upper_flag <= 1'b1;
                    end
                    if (r_eob) begin
                        r_finished <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit) begin
                r_head <= head_inc;
                r_cnt  <= r_cnt - CW'(1);
            end
            if (i_cmd.store) begin
                r_cnt <= r_cnt + CW'(1);
                if (i_cmd.new_token) begin
                    r_upper_flag <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[tail_ptr] <= r_n;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.tail) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_byte    <= r_upper_flag ? clt_pkg::to_upper(r_rd_data) : r_rd_data;
            r_out.byte_valid  <= 1'b1;
            r_out.param_count <= r_bcount;
            r_out.parse_done  <= 1'b0;
            r_out.run_last    <= i_cmd.last;
        end else if (i_cmd.tail) begin
            r_out.out_byte    <= i_cmd.tail_status ? clt_pkg::ZERO_BYTE : r_n;
            r_out.byte_valid  <= !i_cmd.tail_status;
            r_out.param_count <= r_bcount;
            r_out.parse_done  <= 1'b1;
            r_out.run_last    <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sim/clt_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the command line tokeniser testbench. It predicts the rewritten
// byte stream for each accepted input request and checks every output request.
// Depends on clt_pkg for the request types, register indexes and character constants.
package clt_tb_pkg;
    import clt_pkg::*;

    class token_scoreboard;
        logic        ignore_quotes;
        logic        upper_keys;
        logic        key_value_mode;
        logic [7:0]  separator;
        logic [7:0]  held[$];
        int          key_len;
        logic        in_string;
        logic        prev_zero;
        logic [15:0] boundaries;
        logic        finished;
        t_out_req    staged;
        bit          staged_valid;
        t_out_req    rewritten_q[$];
        int unsigned errors;

        function new();
            ignore_quotes  = 1'b0;
            upper_keys     = 1'b1;
            key_value_mode = 1'b0;
            separator      = 8'h20;
            key_len        = 0;
            in_string      = 1'b0;
            prev_zero      = 1'b0;
            boundaries     = '0;
            finished       = 1'b1;
            staged_valid   = 1'b0;
            errors         = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [7:0] d);
            case (idx)
                CFG_IGNORE_QUOTES: ignore_quotes  = d[0];
                CFG_UPPER_KEYS:    upper_keys     = d[0];
                CFG_KV_MODE:       key_value_mode = d[0];
                CFG_SEPARATOR:     separator      = d;
                default: ;
            endcase
        endfunction

        function int pending();
            return rewritten_q.size();
        endfunction

        // The last request of a burst is held back until the burst is known to be over,
        // so that its run_last flag can be set.
        function void emit(logic [7:0] b, logic v, logic d);
            if (staged_valid) begin
                rewritten_q.push_back(staged);
            end
            staged.out_byte    = b;
            staged.byte_valid  = v;
            staged.param_count = boundaries;
            staged.parse_done  = d;
            staged.run_last    = 1'b0;
            staged_valid       = 1'b1;
        endfunction

        function void close_burst();
            if (staged_valid) begin
                staged.run_last = 1'b1;
                rewritten_q.push_back(staged);
                staged_valid = 1'b0;
            end
        endfunction

        function void release_held();
            foreach (held[j]) begin
                emit(held[j], 1'b1, 1'b0);
            end
            held.delete();
            key_len = 0;
        endfunction

        // Returns 1 when the request is taken by the parser, 0 when it is ignored.
        function bit note_request(t_in_req r);
            logic [7:0] b;
            logic [7:0] n;
            int         j;
            b = r.in_byte;
            n = b;
            if (r.first_byte) begin
                held.delete();
                key_len    = 0;
                in_string  = 1'b0;
                prev_zero  = 1'b1;
                boundaries = '0;
                finished   = 1'b0;
            end else if (finished) begin
                return 1'b0;
            end

            if (b == ZERO_BYTE || boundaries >= COUNT_LIMIT) begin
                release_held();
                emit(ZERO_BYTE, 1'b0, 1'b1);
                finished = 1'b1;
                close_burst();
                return 1'b1;
            end

            if (!ignore_quotes && b == QUOTE_CHAR) begin
                n = ZERO_BYTE;
                in_string = ~in_string;
            end else if (!in_string && b == separator) begin
                n = ZERO_BYTE;
            end else if (!in_string && key_value_mode && b == EQUALS_CHAR) begin
                n = ZERO_BYTE;
                if (upper_keys) begin
                    for (j = 0; j < key_len; j++) begin
                        if (held[j] >= 8'h61 && held[j] <= 8'h7A) begin
                            held[j] = held[j] - 8'h20;
                        end
                    end
                end
            end

            if (n == ZERO_BYTE && !prev_zero) begin
                boundaries = boundaries + 16'd1;
            end

            if (r.end_of_buffer) begin
                release_held();
                emit(n, 1'b1, 1'b1);
                finished = 1'b1;
            end else if (n != ZERO_BYTE && prev_zero) begin
                release_held();
                held.push_back(n);
                key_len = 1;
            end else begin
                if (held.size() >= HOLD_DEPTH_DEF) begin
                    emit(held[0], 1'b1, 1'b0);
                    void'(held.pop_front());
                    if (key_len > 0) begin
                        key_len--;
                    end
                end
                held.push_back(n);
                if (n != ZERO_BYTE) begin
                    key_len++;
                end
            end
            prev_zero = (n == ZERO_BYTE);
            close_burst();
            return 1'b1;
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h, got %h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            if (rewritten_q.size() == 0) begin
                $display("%0t: unexpected request, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = rewritten_q.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("byte_valid", 16'(want.byte_valid), 16'(got.byte_valid));
            compare_field("param_count", want.param_count, got.param_count);
            compare_field("parse_done", 16'(want.parse_done), 16'(got.parse_done));
            compare_field("run_last", 16'(want.run_last), 16'(got.run_last));
        endfunction
    endclass

endpackage

@@ sim/command_line_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the command line tokeniser: directed and random commands with
// random idling on both sides, checked request by request against the scoreboard.
// Depends on clt_pkg, clt_tb_pkg and the command_line_tokenizer block.
module command_line_tokenizer_tb;
    import clt_pkg::*;
    import clt_tb_pkg::*;

    localparam int SETTLE_CYCLES   = 2 * HOLD_DEPTH_DEF + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int NUM_PHASES      = 7;
    localparam int PHASE_ITEMS     = 35;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_req               in_req      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_req              o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    token_scoreboard sb;
    t_in_req         cmd_q[$];
    logic [7:0]      cur_sep        = 8'h20;
    logic            cur_kv         = 1'b0;
    bit              open_cmd       = 1'b0;
    int              hold_off_asked = 0;
    int              send_gap_max   = 15;
    int              recv_gap_max   = 15;
    int              taken_items    = 0;

    command_line_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(int max);
        if (max == 0) begin
            return 0;
        end
        return $urandom_range(0, max);
    endfunction

    function automatic void put_item(logic [7:0] b, logic f, logic e);
        t_in_req r;
        r.in_byte       = b;
        r.first_byte    = f | open_cmd;
        r.end_of_buffer = e;
        open_cmd        = 1'b0;
        cmd_q.push_back(r);
    endfunction

    function automatic logic [7:0] token_char();
        case ($urandom_range(0, 5))
            0, 1:    return 8'h61 + 8'($urandom_range(0, 25));
            2:       return 8'h41 + 8'($urandom_range(0, 25));
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // A command of one to five tokens, some quoted and some of 30 to 45 bytes, which can exceed the hold.
    task automatic build_command();
        int ntok;
        int len;
        bit quoted;
        int t;
        int k;
        ntok = $urandom_range(1, 5);
        open_cmd = 1'b1;
        for (t = 0; t < ntok; t++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 8);
            quoted = ($urandom_range(0, 4) == 0);
            if (quoted) begin
                put_item(QUOTE_CHAR, 1'b0, 1'b0);
            end
            for (k = 0; k < len; k++) begin
                put_item(token_char(), 1'b0, 1'b0);
            end
            if (quoted) begin
                put_item(QUOTE_CHAR, 1'b0, 1'b0);
            end
            if (t < ntok - 1) begin
                case ($urandom_range(0, 3))
                    0: put_item(cur_sep, 1'b0, 1'b0);
                    1: begin
                        put_item(cur_sep, 1'b0, 1'b0);
                        put_item(cur_sep, 1'b0, 1'b0);
                    end
                    2: put_item(cur_kv ? EQUALS_CHAR : cur_sep, 1'b0, 1'b0);
                    default: begin
                        put_item(EQUALS_CHAR, 1'b0, 1'b0);
                        put_item(cur_sep, 1'b0, 1'b0);
                    end
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0, 1:    put_item(ZERO_BYTE, 1'b0, 1'b0);
            2:       ;
            default: put_item(token_char(), 1'b0, 1'b1);
        endcase
    endtask

    task automatic send(t_in_req r);
        int gap;
        gap = draw_gap(send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        in_req     <= r;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (sb.note_request(r)) begin
            taken_items++;
        end
    endtask

    task automatic send_queue();
        while (cmd_q.size() > 0) begin
            send(cmd_q.pop_front());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        sb.set_register(idx, d);
    endtask

    task automatic program_regs(logic iq, logic uk, logic kv, logic [7:0] sep);
        write_reg(CFG_IGNORE_QUOTES, {7'($urandom_range(0, 127)), iq});
        write_reg(CFG_UPPER_KEYS, {7'($urandom_range(0, 127)), uk});
        write_reg(CFG_KV_MODE, {7'($urandom_range(0, 127)), kv});
        write_reg(CFG_SEPARATOR, sep);
        i_cfg_we <= 1'b0;
        cur_sep = sep;
        cur_kv  = kv;
    endtask

    initial begin : result_side
        int gap;
        int served;
        int hold_off_seen;
        served = 0;
        hold_off_seen = 0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_off_seen != hold_off_asked) begin
                hold_off_seen = hold_off_asked;
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = draw_gap(recv_gap_max);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result(o_out_data);
            served++;
            if (served % 48 == 0) begin
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
            end
        end
    end

    initial begin : stimulus
        int  p;
        int  phase_goal;
        bit  paused;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: a byte before any command, an empty command, quoting.
        put_item("x", 1'b0, 1'b0);
        put_item(ZERO_BYTE, 1'b1, 1'b0);
        put_item("a", 1'b1, 1'b0);
        put_item(" ", 1'b0, 1'b0);
        put_item(QUOTE_CHAR, 1'b0, 1'b0);
        put_item("b", 1'b0, 1'b0);
        put_item(" ", 1'b0, 1'b0);
        put_item(QUOTE_CHAR, 1'b0, 1'b0);
        put_item(8'hFF, 1'b0, 1'b1);
        send_queue();
        drain();

        // Key-value mode: equals before any token, after zeros, and a new command
        // arriving while bytes are still held.
        program_regs(1'b0, 1'b1, 1'b1, 8'h20);
        put_item(EQUALS_CHAR, 1'b1, 1'b0);
        put_item("k", 1'b0, 1'b0);
        put_item("y", 1'b0, 1'b0);
        put_item(EQUALS_CHAR, 1'b0, 1'b0);
        put_item(EQUALS_CHAR, 1'b0, 1'b0);
        put_item(" ", 1'b0, 1'b0);
        put_item(EQUALS_CHAR, 1'b0, 1'b0);
        put_item("v", 1'b0, 1'b0);
        put_item(ZERO_BYTE, 1'b0, 1'b0);
        put_item("a", 1'b1, 1'b0);
        put_item("b", 1'b0, 1'b0);
        put_item("c", 1'b1, 1'b0);
        put_item("d", 1'b0, 1'b1);
        put_item("q", 1'b0, 1'b0);
        send_queue();

        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0:       program_regs(1'b0, 1'b1, 1'b1, 8'h20);
                1:       program_regs(1'b1, 1'b0, 1'b1, 8'h2C);
                2:       program_regs(1'b0, 1'b1, 1'b1, 8'hFF);
                3:       program_regs(1'b0, 1'b1, 1'b0, 8'h00);
                4:       program_regs(1'b0, 1'b0, 1'b1, EQUALS_CHAR);
                5:       program_regs(1'b1, 1'b1, 1'b1, QUOTE_CHAR);
                default: program_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            endcase
            phase_goal = taken_items + PHASE_ITEMS;
            paused = 1'b0;
            if (p == 1) begin
                hold_off_asked++;
                send_gap_max = 0;
                repeat (3) build_command();
                send_queue();
            end
            while (taken_items < phase_goal) begin
                if (p == 3 && !paused && taken_items >= phase_goal - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        put_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                                 ($urandom_range(0, 7) == 0));
                    end
                end else begin
                    build_command();
                end
                send_queue();
            end
        end

        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #(100_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ command_line_tokenizer.f @@
design/clt_pkg.sv
design/clt_ctrl.sv
design/clt_dp.sv
design/command_line_tokenizer.sv
sim/clt_tb_pkg.sv
sim/command_line_tokenizer_tb.sv
